### rtl/wsmc_pkg.sv
// Shared types and constants for the word substring match counter.
package wsmc_pkg;

   localparam int KEY_MAX_DEFAULT    = 16;
   localparam int COUNT_BITS_DEFAULT = 32;

   localparam int CHAR_BITS   = 8;
   localparam int LEN_BITS    = 5;
   localparam int KEYREG_BITS = 64;
   localparam int CSR_BITS    = 2;
   localparam int TOTAL_BITS  = 32;

   // Configuration register indexes.
   localparam logic [CSR_BITS-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_KEY_LEN  = 2'd2;

   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_CR      = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CASE_BIT     = 8'h20;

   // Control broadcast from the top level to every match cell.
   typedef struct packed {
      logic                 step;
      logic                 clear;
      logic [CHAR_BITS-1:0] letter;
      logic [LEN_BITS-1:0]  length;
   } cell_ctl_type;

endpackage

### rtl/word_substring_match_counter.sv
// Top level: streaming word counter with substring hit counting.
//
// Text enters on the req_ channel one byte per transaction, with
// req_line_last set on the last byte of each line. Letters form words,
// whitespace or a line end closes a word, other bytes are skipped.
// Every input transaction yields exactly one rsp_ transaction carrying the
// word and hit totals after that byte and a flag for a word that closed.
// The result is registered: it is valid in the cycle after acceptance.
// Throughput is one byte per cycle unless the receiver stalls, set by the row of
// match cells, which all update their partial-match bits in parallel on each letter.
// The totals live in the output register itself; when the receiver stalls,
// req_ready drops until the pending result is taken, and a new byte is
// taken in the same cycle that the old result leaves.
// The csr_ channel writes the key (low chars, high chars, length) and is
// always ready; write it only while no transaction is in flight.
// Synchronous reset clears the key, the word state, both counters and the
// output valid; no clearing pass is needed.
module word_substring_match_counter #(
   parameter int KEY_MAX    = wsmc_pkg::KEY_MAX_DEFAULT,
   parameter int COUNT_BITS = wsmc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [wsmc_pkg::CHAR_BITS-1:0]   req_text_byte,
   input  logic                             req_line_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [wsmc_pkg::TOTAL_BITS-1:0]  rsp_word_total,
   output logic [wsmc_pkg::TOTAL_BITS-1:0]  rsp_hit_total,
   output logic                             rsp_word_closed,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wsmc_pkg::CSR_BITS-1:0]    csr_index,
   input  logic [wsmc_pkg::KEYREG_BITS-1:0] csr_data
);

   localparam logic [wsmc_pkg::LEN_BITS-1:0] LEN_MAX = wsmc_pkg::LEN_BITS'(KEY_MAX);

   logic [wsmc_pkg::KEYREG_BITS-1:0]   key_low_ff;
   logic [wsmc_pkg::KEYREG_BITS-1:0]   key_high_ff;
   logic [wsmc_pkg::LEN_BITS-1:0]      key_len_ff;
   logic [2*wsmc_pkg::KEYREG_BITS-1:0] key_chars;
   logic [wsmc_pkg::LEN_BITS-1:0]      len_used;

   logic inside_ff;
   logic inside_in;
   logic hit_ff;
   logic hit_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic closed_ff;
   logic closed_in;

   logic                           accept;
   logic [wsmc_pkg::CHAR_BITS-1:0] lower;
   logic                           is_letter;
   logic                           is_space;
   logic                           word_close;
   logic                           word_hit;
   wsmc_pkg::cell_ctl_type         ctl;

   logic [KEY_MAX:0]   chain_bits;
   logic [KEY_MAX-1:0] tail_hits;

   logic [COUNT_BITS-1:0]                      word_cnt;
   logic [COUNT_BITS-1:0]                      hit_cnt;
   logic [COUNT_BITS+wsmc_pkg::TOTAL_BITS-1:0] word_ext;
   logic [COUNT_BITS+wsmc_pkg::TOTAL_BITS-1:0] hit_ext;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            wsmc_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_data;
            wsmc_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data;
            wsmc_pkg::CSR_KEY_LEN:  key_len_ff  <= csr_data[wsmc_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign key_chars = {key_high_ff, key_low_ff};
   assign len_used  = (key_len_ff > LEN_MAX) ? LEN_MAX : key_len_ff;

   // Byte classification.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lower = req_text_byte;
      if (req_text_byte >= wsmc_pkg::CHAR_UPPER_A && req_text_byte <= wsmc_pkg::CHAR_UPPER_Z) begin
         lower = req_text_byte | wsmc_pkg::CASE_BIT;
      end
   end

   assign is_letter = lower >= wsmc_pkg::CHAR_LOWER_A && lower <= wsmc_pkg::CHAR_LOWER_Z;
   assign is_space  = (lower == wsmc_pkg::CHAR_SPACE) ||
                      (lower >= wsmc_pkg::CHAR_TAB && lower <= wsmc_pkg::CHAR_CR);

   // A letter that carries the line end opens or extends a word and closes it at once.
   assign word_close = (inside_ff || is_letter) && (is_space || req_line_last);

   assign ctl.step   = accept && is_letter;
   assign ctl.clear  = accept && word_close;
   assign ctl.letter = lower;
   assign ctl.length = len_used;

   // Match cells: cell j passes its bit to cell j+1; cell 0 always sees a fresh start.
   assign chain_bits[0] = 1'b1;

   for (genvar j = 0; j < KEY_MAX; j++) begin : g_cell
      wsmc_match_cell #(
         .POS(j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .key_char (key_chars[wsmc_pkg::CHAR_BITS*j +: wsmc_pkg::CHAR_BITS]),
         .prev_bit (chain_bits[j]),
         .match_ff (chain_bits[j+1]),
         .tail_hit (tail_hits[j])
      );
   end

   always_comb begin
      word_hit = hit_ff;
      if (is_letter) begin
         word_hit = (inside_ff ? hit_ff : (len_used == '0)) || (|tail_hits);
      end
   end

   always_comb begin
      inside_in    = inside_ff;
      hit_in       = hit_ff;
      closed_in    = closed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         inside_in    = (inside_ff || is_letter) && !word_close;
         hit_in       = word_hit && !word_close;
         closed_in    = word_close;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         closed_ff    <= 1'b0;
      end else begin
         inside_ff    <= inside_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         closed_ff    <= closed_in;
      end
   end

   // The counters double as the output payload register.
   wsmc_sat_counter #(
      .COUNT_BITS(COUNT_BITS)
   ) u_word_cnt (
      .clock    (clock),
      .reset    (reset),
      .inc      (accept && word_close),
      .count_ff (word_cnt)
   );

   wsmc_sat_counter #(
      .COUNT_BITS(COUNT_BITS)
   ) u_hit_cnt (
      .clock    (clock),
      .reset    (reset),
      .inc      (accept && word_close && word_hit),
      .count_ff (hit_cnt)
   );

   assign word_ext = {{wsmc_pkg::TOTAL_BITS{1'b0}}, word_cnt};
   assign hit_ext  = {{wsmc_pkg::TOTAL_BITS{1'b0}}, hit_cnt};

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_total  = word_ext[wsmc_pkg::TOTAL_BITS-1:0];
   assign rsp_hit_total   = hit_ext[wsmc_pkg::TOTAL_BITS-1:0];
   assign rsp_word_closed = closed_ff;

   a_hit_le_word: assert property (@(posedge clock) disable iff (reset)
      hit_cnt <= word_cnt)
      else $error("hit count exceeds word count");

   a_word_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> word_cnt >= $past(word_cnt))
      else $error("word count decreased");

   a_idle_bits_clear: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> (chain_bits[KEY_MAX:1] == '0) && !hit_ff)
      else $error("match state left over outside a word");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted byte produced no result");

endmodule

### rtl/wsmc_match_cell.sv
// One shift-and match cell: holds one key position's partial-match bit.
module wsmc_match_cell #(
   parameter int POS = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wsmc_pkg::cell_ctl_type         ctl,
   input  logic [wsmc_pkg::CHAR_BITS-1:0] key_char,
   input  logic                           prev_bit,
   output logic                           match_ff,
   output logic                           tail_hit
);

   localparam logic [wsmc_pkg::LEN_BITS-1:0] POS_CODE  = wsmc_pkg::LEN_BITS'(POS);
   localparam logic [wsmc_pkg::LEN_BITS-1:0] POS_NEXT  = wsmc_pkg::LEN_BITS'(POS + 1);

   logic used;
   logic tail;
   logic step_bit;
   logic match_in;

   assign used     = POS_CODE < ctl.length;
   assign tail     = POS_NEXT == ctl.length;
   assign step_bit = prev_bit && used && (key_char == ctl.letter);

   // The bit seen by the hit logic is the one after this letter, before any close.
   assign tail_hit = ctl.step && tail && step_bit;

   always_comb begin
      match_in = match_ff;
      if (ctl.step) begin
         match_in = step_bit;
      end
      if (ctl.clear) begin
         match_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

### rtl/wsmc_sat_counter.sv
// Saturating event counter.
module wsmc_sat_counter #(
   parameter int COUNT_BITS = wsmc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  inc,
   output logic [COUNT_BITS-1:0] count_ff
);

   logic [COUNT_BITS-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (inc && (count_ff != {COUNT_BITS{1'b1}})) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
